### hw/rtl/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg: shared types and constants of the sorted key table
// Item structs, status codes, controller states and the cell control group.
// ----------------------------------------------------------------------------
package skt_pkg;

  // key width and default table depth
  localparam int KEY_W           = 48;
  localparam int MAX_ENTRIES_DEF = 256;
  localparam int POS_W           = 8;
  localparam int OCC_W           = 9;
  localparam int STATUS_W        = 2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // input item
  typedef struct packed {
    logic             operation;
    logic [KEY_W-1:0] key;
  } skt_in_t;

  // result item
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [OCC_W-1:0]    occupancy;
  } skt_out_t;

  // controller states
  typedef enum logic {
    SKT_IDLE,
    SKT_UPDATE
  } skt_state_t;

  // control group broadcast to every cell
  typedef struct packed {
    logic cmp_en;  // capture compare flags against the incoming key
    logic ins_en;  // open a slot and shift up
    logic rem_en;  // close the hit slot and shift down
  } skt_cell_ctl_t;

endpackage

### hw/rtl/skt_cell.sv
// ----------------------------------------------------------------------------
// skt_cell: one slot of the sorted key table
// Holds one key, compares it with the incoming key and shifts with its
// neighbors on insert and remove.
// ----------------------------------------------------------------------------
module skt_cell (
  input  logic                     clk,
  input  skt_pkg::skt_cell_ctl_t   ctl,
  input  logic                     slot_used,   // slot index below entry count
  input  logic [skt_pkg::KEY_W-1:0] cmp_key,    // key at input transfer
  input  logic [skt_pkg::KEY_W-1:0] ins_key,    // held key for insert
  input  logic                     left_le,
  input  logic [skt_pkg::KEY_W-1:0] left_entry,
  input  logic                     right_le,
  input  logic [skt_pkg::KEY_W-1:0] right_entry,
  output logic [skt_pkg::KEY_W-1:0] entry,
  output logic                     le,
  output logic                     ins_hit,
  output logic                     rem_hit
);
  import skt_pkg::*;

  logic [KEY_W-1:0] entry_r;
  logic             le_r;
  logic             eq_r;

  // compare flags, sampled once per item
  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      le_r <= slot_used && (entry_r <= cmp_key);
      eq_r <= (entry_r == cmp_key);
    end
  end

  // shift up behind the insert slot, shift down from the removed slot
  always_ff @(posedge clk) begin
    if (ctl.ins_en && !le_r) begin
      entry_r <= left_le ? ins_key : left_entry;
    end else if (ctl.rem_en && !right_le) begin
      entry_r <= right_entry;
    end
  end

  // this slot is the insert boundary or the last equal entry
  assign ins_hit = !le_r && left_le;
  assign rem_hit = le_r && !right_le && eq_r;

  assign entry = entry_r;
  assign le    = le_r;

endmodule

### hw/rtl/skt_locate.sv
// ----------------------------------------------------------------------------
// skt_locate: hit slot encoder
// Turns the one-hot hit flags of the cell row into a slot index and a
// found flag for remove.
// ----------------------------------------------------------------------------
module skt_locate #(
  parameter int MAX_ENTRIES = skt_pkg::MAX_ENTRIES_DEF
) (
  input  logic                           operation,
  input  logic [MAX_ENTRIES-1:0]         ins_hit,
  input  logic [MAX_ENTRIES-1:0]         rem_hit,
  output logic [$clog2(MAX_ENTRIES)-1:0] slot,
  output logic                           found
);
  import skt_pkg::*;

  localparam int IW = $clog2(MAX_ENTRIES);

  logic [MAX_ENTRIES-1:0] hit;

  // pick the flag set of the current operation
  assign hit = (operation == OP_REMOVE) ? rem_hit : ins_hit;

  // one-hot to binary, an or tree over the row
  always_comb begin
    slot = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (hit[i]) begin
        slot = slot | IW'(i);
      end
    end
  end

  assign found = |rem_hit;

endmodule

### hw/rtl/sorted_key_table.sv
// ----------------------------------------------------------------------------
// sorted_key_table: sorted table of region base addresses
// Row of compare-and-shift cells with a two-state controller and an output
// register.
// ----------------------------------------------------------------------------
// Keeps up to MAX_ENTRIES 48-bit keys in ascending order, one key per cell.
// An insert goes after all equal keys and is refused with status full when
// the table holds MAX_ENTRIES keys; a remove takes the last equal key and
// reports not found when there is none. For each item, the cycle of its input
// transfer samples every cell's compare against the key, and the update state
// after it shifts the whole row at once and loads the result register.
// A result that waits on out_stall holds the update cycle of the next item,
// and the input is stalled while an item is in its update cycle. Position
// and occupancy carry the low 8 and 9 bits of the slot index and the count.
module sorted_key_table #(
  parameter int MAX_ENTRIES = skt_pkg::MAX_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  skt_pkg::skt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output skt_pkg::skt_out_t out_data
);
  import skt_pkg::*;

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_ENTRIES);

  skt_state_t       state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             op_r;
  logic [KEY_W-1:0] key_r;
  logic             out_valid_r, out_valid_nxt;
  skt_out_t         out_data_r, out_data_nxt;

  logic             in_xfer;
  logic             commit;
  logic             full;
  logic             found;
  logic [IW-1:0]    slot;
  skt_cell_ctl_t    cell_ctl;

  logic [KEY_W-1:0]       entry [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] le;
  logic [MAX_ENTRIES-1:0] ins_hit;
  logic [MAX_ENTRIES-1:0] rem_hit;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SKT_IDLE: begin
        if (in_valid) begin
          state_nxt = SKT_UPDATE;
        end
      end
      SKT_UPDATE: begin
        if (!(out_valid_r && out_stall)) begin
          state_nxt = SKT_IDLE;
        end
      end
      default: state_nxt = SKT_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    in_stall = 1'b1;
    commit   = 1'b0;
    unique case (state_r)
      SKT_IDLE:   in_stall = 1'b0;
      SKT_UPDATE: commit   = !(out_valid_r && out_stall);
      default: begin
        in_stall = 1'b1;
        commit   = 1'b0;
      end
    endcase
  end

  assign in_xfer = in_valid && !in_stall;
  assign full    = (count_r == COUNT_MAX);

  // control group for the cell row
  always_comb begin
    cell_ctl.cmp_en = in_xfer;
    cell_ctl.ins_en = commit && (op_r == OP_INSERT) && !full;
    cell_ctl.rem_en = commit && (op_r == OP_REMOVE) && found;
  end

  // cell row
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);
    logic             left_le_w;
    logic [KEY_W-1:0] left_entry_w;
    logic             right_le_w;
    logic [KEY_W-1:0] right_entry_w;

    if (i == 0) begin : g_first
      assign left_le_w    = 1'b1;
      assign left_entry_w = key_r;
    end else begin : g_mid_left
      assign left_le_w    = le[i-1];
      assign left_entry_w = entry[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_last
      assign right_le_w    = 1'b0;
      assign right_entry_w = entry[i];
    end else begin : g_mid_right
      assign right_le_w    = le[i+1];
      assign right_entry_w = entry[i+1];
    end

    skt_cell u_cell (
      .clk         (clk),
      .ctl         (cell_ctl),
      .slot_used   (IDX < count_r),
      .cmp_key     (in_data.key),
      .ins_key     (key_r),
      .left_le     (left_le_w),
      .left_entry  (left_entry_w),
      .right_le    (right_le_w),
      .right_entry (right_entry_w),
      .entry       (entry[i]),
      .le          (le[i]),
      .ins_hit     (ins_hit[i]),
      .rem_hit     (rem_hit[i])
    );
  end

  // hit slot encoder
  skt_locate #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_locate (
    .operation (op_r),
    .ins_hit   (ins_hit),
    .rem_hit   (rem_hit),
    .slot      (slot),
    .found     (found)
  );

  // entry count and result
  always_comb begin
    logic [IW+POS_W-1:0] slot_ext;
    logic [CW+OCC_W-1:0] occ_ext;

    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    slot_ext      = {{POS_W{1'b0}}, slot};

    if (cell_ctl.ins_en) begin
      count_nxt = count_r + CW'(1);
    end else if (cell_ctl.rem_en) begin
      count_nxt = count_r - CW'(1);
    end
    occ_ext = {{OCC_W{1'b0}}, count_nxt};

    if (commit) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.occupancy = occ_ext[OCC_W-1:0];
      out_data_nxt.position  = slot_ext[POS_W-1:0];
      out_data_nxt.status    = ST_OK;
      if (op_r == OP_INSERT) begin
        if (full) begin
          out_data_nxt.status   = ST_FULL;
          out_data_nxt.position = '0;
        end
      end else if (!found) begin
        out_data_nxt.status   = ST_ABSENT;
        out_data_nxt.position = '0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SKT_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r  <= in_data.operation;
      key_r <= in_data.key;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### verif/sorted_key_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_checker: result predictor and scoreboard
// Watches both channels of the sorted key table, keeps its own sorted copy of
// the table, predicts one result per input transfer and compares every result
// transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module sorted_key_table_checker #(
  parameter int MAX_ENTRIES = skt_pkg::MAX_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  skt_pkg::skt_in_t   in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  skt_pkg::skt_out_t  out_data,
  output int                 fail_count,
  output int                 pending_count,
  output int                 result_count,
  output int                 full_count,
  output int                 absent_count
);
  import skt_pkg::*;

  // shadow table, ascending, only slots below shadow_size are meaningful
  logic [KEY_W-1:0] shadow_keys [MAX_ENTRIES];
  int unsigned      shadow_size;

  // predicted results in transfer order
  skt_out_t         expected_results [$];

  // apply one operation to the shadow table and return its result
  function automatic skt_out_t apply_op(input skt_in_t item);
    int unsigned slot;
    int unsigned i;
    skt_out_t    res;
    slot = 0;
    while (slot < shadow_size && shadow_keys[slot] <= item.key) slot++;
    res.status   = ST_OK;
    res.position = '0;
    if (item.operation == OP_INSERT) begin
      if (shadow_size >= MAX_ENTRIES) begin
        res.status = ST_FULL;
      end else begin
        // open the slot after every key not above the new one
        for (i = shadow_size; i > slot; i--) shadow_keys[i] = shadow_keys[i-1];
        shadow_keys[slot] = item.key;
        shadow_size++;
        res.position = POS_W'(slot);
      end
    end else begin
      // the last equal key sits just below the insert point
      if (slot == 0 || shadow_keys[slot-1] != item.key) begin
        res.status = ST_ABSENT;
      end else begin
        for (i = slot - 1; i + 1 < shadow_size; i++) shadow_keys[i] = shadow_keys[i+1];
        shadow_size--;
        res.position = POS_W'(slot - 1);
      end
    end
    res.occupancy = OCC_W'(shadow_size);
    return res;
  endfunction

  // one field compare, widened to the widest result field
  task automatic check_field(input string label, input logic [OCC_W-1:0] want,
                             input logic [OCC_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
      fail_count++;
    end
  endtask

  // track transfers on both channels
  always @(posedge clk) begin : track
    skt_out_t want;
    if (!rst_n) begin
      shadow_size = 0;
      expected_results.delete();
      fail_count    = 0;
      pending_count = 0;
      result_count  = 0;
      full_count    = 0;
      absent_count  = 0;
    end else begin
      if (out_valid && !out_stall) begin
        result_count++;
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected, status %0d position %0d occupancy %0d",
                   $time, out_data.status, out_data.position, out_data.occupancy);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", OCC_W'(want.status), OCC_W'(out_data.status));
          check_field("position", OCC_W'(want.position), OCC_W'(out_data.position));
          check_field("occupancy", want.occupancy, out_data.occupancy);
          if (want.status == ST_FULL) full_count++;
          if (want.status == ST_ABSENT) absent_count++;
        end
      end
      if (in_valid && !in_stall) expected_results.push_back(apply_op(in_data));
      pending_count = expected_results.size();
    end
  end

endmodule

### verif/sorted_key_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_test: top level testbench of the sorted key table
// Drives directed corner operations, then insert-heavy, remove-heavy and mixed
// random phases with random sender gaps and receiver stalls; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module sorted_key_table_test;
  import skt_pkg::*;

  localparam int TABLE_DEPTH = MAX_ENTRIES_DEF;
  localparam int CYCLE_LIMIT = 500000;
  localparam int LONG_HOLD   = 300;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  skt_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  skt_out_t out_data;

  int fail_count;
  int pending_count;
  int result_count;
  int full_count;
  int absent_count;

  int cycle_count = 0;
  int insert_count = 0;
  int remove_count = 0;
  bit sender_calm = 1'b0;

  // keys that are probably in the table, used to aim removes at hits
  logic [KEY_W-1:0] live_keys [$];

  sorted_key_table #(.MAX_ENTRIES(TABLE_DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  sorted_key_table_checker #(.MAX_ENTRIES(TABLE_DEPTH)) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending_count(pending_count),
    .result_count (result_count),
    .full_count   (full_count),
    .absent_count (absent_count)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // key mix: extremes, a small range for duplicates, near-top and full random
  function automatic logic [KEY_W-1:0] pick_key();
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return KEY_W'($urandom_range(0, 15));
      5:       return {KEY_W{1'b1}} - KEY_W'($urandom_range(0, 15));
      default: return wide[KEY_W-1:0];
    endcase
  endfunction

  // one input transfer after a random gap
  task automatic send_item(input logic op, input logic [KEY_W-1:0] key);
    int      gap;
    skt_in_t item;
    gap = sender_calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.operation = op;
    item.key       = key;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == OP_INSERT) insert_count++;
    else remove_count++;
  endtask

  // stop offering and wait until every predicted result has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_count == 0);
    @(posedge clk);
  endtask

  // random operations, removes mostly aimed at keys inserted earlier
  task automatic run_phase(input int count, input int insert_pct);
    int               n;
    int               idx;
    logic [KEY_W-1:0] key;
    for (n = 0; n < count; n++) begin
      if (n % 40 == 0) sender_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(1, 100) <= insert_pct) begin
        key = pick_key();
        if (live_keys.size() < TABLE_DEPTH) live_keys.push_back(key);
        send_item(OP_INSERT, key);
      end else if (live_keys.size() > 0 && $urandom_range(0, 9) != 0) begin
        idx = $urandom_range(0, live_keys.size() - 1);
        key = live_keys[idx];
        live_keys.delete(idx);
        send_item(OP_REMOVE, key);
      end else begin
        send_item(OP_REMOVE, pick_key());
      end
    end
  endtask

  // receiver: random stalls per result, quiet stretches, two long hold-offs
  initial begin : receiver
    int gap;
    int taken;
    bit calm;
    taken = 0;
    calm  = 1'b0;
    out_stall <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (taken % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      if (taken == 120 || taken == 1000) gap = LONG_HOLD;
      else gap = calm ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, extremes, duplicates, absent keys, back to empty
    send_item(OP_REMOVE, KEY_W'(5));
    send_item(OP_INSERT, '0);
    send_item(OP_INSERT, '1);
    send_item(OP_INSERT, '1);
    send_item(OP_INSERT, 48'h8000_0000_0000);
    send_item(OP_INSERT, '0);
    send_item(OP_REMOVE, '1);
    send_item(OP_REMOVE, KEY_W'(1));
    send_item(OP_REMOVE, 48'h8000_0000_0000);
    send_item(OP_REMOVE, '1);
    send_item(OP_REMOVE, '1);
    send_item(OP_INSERT, 48'h5555_5555_5555);
    send_item(OP_INSERT, 48'hAAAA_AAAA_AAAA);
    send_item(OP_REMOVE, '0);
    send_item(OP_REMOVE, '0);
    send_item(OP_REMOVE, '0);
    send_item(OP_REMOVE, 48'hAAAA_AAAA_AAAA);
    send_item(OP_REMOVE, 48'h5555_5555_5555);
    send_item(OP_REMOVE, '0);
    wait_idle();

    // fill to full and keep pushing refused inserts
    run_phase(600, 85);
    wait_idle();
    // drain to empty and keep hitting absent keys
    run_phase(600, 15);
    wait_idle();
    // balanced churn
    run_phase(350, 50);
    wait_idle();
    repeat (8) @(posedge clk);

    $display("sent %0d inserts and %0d removes over %0d cycles",
             insert_count, remove_count, cycle_count);
    $display("checked %0d results: %0d refused as full, %0d not found",
             result_count, full_count, absent_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### sorted_key_table.f
hw/rtl/skt_pkg.sv
hw/rtl/skt_cell.sv
hw/rtl/skt_locate.sv
hw/rtl/sorted_key_table.sv
verif/sorted_key_table_checker.sv
verif/sorted_key_table_test.sv
